// ===== sv/rgc_pkg.sv =====
`default_nettype none

package rgc_pkg;

  localparam int TIME_W  = 32;
  localparam int NONCE_W = 32;

  // Result codes, in the order in which the checks are applied.
  typedef enum logic [2:0] {
    VERDICT_OK     = 3'd0,
    VERDICT_OLD    = 3'd1,
    VERDICT_FUTURE = 3'd2,
    VERDICT_DUP    = 3'd3,
    VERDICT_MAC    = 3'd4
  } verdict_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_SKEW   = 1'b1
  } cfg_reg_t;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd300000;
  localparam logic [TIME_W-1:0] SKEW_RESET   = 32'd60000;

  // One cache entry as it moves along the row of cells.
  typedef struct packed {
    logic               valid;
    logic [TIME_W-1:0]  ts;
    logic [NONCE_W-1:0] nonce;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/rgc_if.sv =====
`default_nettype none

interface rgc_req_if;
  import rgc_pkg::*;

  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  msg_time;
  logic [NONCE_W-1:0] msg_nonce;
  logic [TIME_W-1:0]  now_time;
  logic               mac_match;

  modport source (output valid, msg_time, msg_nonce, now_time, mac_match, input ready);
  modport sink   (input valid, msg_time, msg_nonce, now_time, mac_match, output ready);
endinterface

interface rgc_rsp_if;
  import rgc_pkg::*;

  logic     valid;
  logic     ready;
  logic     accepted;
  verdict_t verdict;

  modport source (output valid, accepted, verdict, input ready);
  modport sink   (input valid, accepted, verdict, output ready);
endinterface

interface rgc_cfg_if;
  import rgc_pkg::*;

  logic              valid;
  logic              ready;
  cfg_reg_t          index;
  logic [TIME_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/rgc_cell.sv =====
`default_nettype none

// One slot of the cache row. When shift is high the cell takes the entry
// of its left neighbor; its valid bit is cleared by reset.
module rgc_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  rgc_pkg::entry_t entry_in,
  output rgc_pkg::entry_t entry_out
);
  import rgc_pkg::*;

  entry_t entry;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry.ts    <= entry_in.ts;
      entry.nonce <= entry_in.nonce;
    end
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (shift) begin
      entry.valid <= entry_in.valid;
    end
  end

  assign entry_out = entry;

endmodule

`default_nettype wire

// ===== sv/replay_guard_cache_core.sv =====
// One item is checked at a time: a new item is taken only when the scan that
// rotates the whole row of cells once past the single comparator at its tail
// is done and its result has entered the output register.
// A result may wait in the output register while the next item is taken.
// Reset (rst, synchronous, active high) empties the cache, restores the
// default window and skew, and drops any item in flight.
`default_nettype none

module replay_guard_cache_core #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst,
  rgc_req_if.sink    req,
  rgc_rsp_if.source  rsp,
  rgc_cfg_if.sink    cfg
);
  import rgc_pkg::*;

  localparam int CNT_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CACHE_ENTRIES - 1);

  // The controller walks through three phases for every item.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers. Writes must be made only while the block is idle;
  // the block itself does not enforce this. The port is always ready.
  logic [TIME_W-1:0] replay_window;
  logic [TIME_W-1:0] skew_allowance;

  // The item under test, captured at the accepting edge. The time checks
  // are done right there and only their outcome is kept.
  logic [TIME_W-1:0]  q_time;
  logic [NONCE_W-1:0] q_nonce;
  logic               q_mac;
  verdict_t           q_pre;
  logic               hit;
  logic [CNT_W-1:0]   scan_cnt;

  // Output register, which lets a result wait without blocking the input.
  logic     rsp_valid;
  logic     rsp_accepted;
  verdict_t rsp_verdict;

  // Row of cells. Cell 0 holds the newest entry and the last cell the
  // oldest. During a scan the row rotates by one place a cycle, so by the
  // end of the scan every entry has passed the tail comparator and
  // the row is back in its original order. An accepted item is pushed in
  // at cell 0 and the oldest entry falls out of the last cell, which keeps
  // exactly the most recent CACHE_ENTRIES accepted messages, the same set
  // that a ring buffer with a write pointer would hold.
  entry_t cell_d [CACHE_ENTRIES];
  entry_t cell_q [CACHE_ENTRIES];
  entry_t feed;
  entry_t fresh;
  logic   shift;
  logic   insert;

  logic              req_take;
  logic              out_free;
  logic              head_match;
  logic [TIME_W-1:0] age;
  logic [TIME_W-1:0] bound;
  verdict_t          pre_verdict;
  verdict_t          final_verdict;

  assign req.ready = (state == ST_IDLE);
  assign req_take  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign out_free  = !rsp_valid || rsp.ready;

  // Both time differences wrap modulo 2^32. A timestamp from the future
  // therefore also looks very old, and the age check, applied first, wins.
  assign age   = req.now_time - req.msg_time;
  assign bound = req.now_time + skew_allowance;

  always_comb begin
    if (age > replay_window) begin
      pre_verdict = VERDICT_OLD;
    end else if (req.msg_time > bound) begin
      pre_verdict = VERDICT_FUTURE;
    end else begin
      pre_verdict = VERDICT_OK;
    end
  end

  // The time checks take precedence over the cache lookup, which in turn
  // takes precedence over the authentication code.
  always_comb begin
    if (q_pre != VERDICT_OK) begin
      final_verdict = q_pre;
    end else if (hit) begin
      final_verdict = VERDICT_DUP;
    end else if (!q_mac) begin
      final_verdict = VERDICT_MAC;
    end else begin
      final_verdict = VERDICT_OK;
    end
  end

  assign head_match = cell_q[CACHE_ENTRIES-1].valid &&
                      (cell_q[CACHE_ENTRIES-1].ts == q_time) &&
                      (cell_q[CACHE_ENTRIES-1].nonce == q_nonce);

  assign insert = (state == ST_FINISH) && out_free && (final_verdict == VERDICT_OK);
  assign shift  = (state == ST_SCAN) || insert;

  assign fresh.valid = 1'b1;
  assign fresh.ts    = q_time;
  assign fresh.nonce = q_nonce;
  assign feed        = (state == ST_SCAN) ? cell_q[CACHE_ENTRIES-1] : fresh;

  for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_d[i] = feed;
    end else begin : g_link
      assign cell_d[i] = cell_q[i-1];
    end

    rgc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .entry_in  (cell_d[i]),
      .entry_out (cell_q[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == CNT_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      scan_cnt       <= '0;
      rsp_valid      <= 1'b0;
      replay_window  <= WINDOW_RESET;
      skew_allowance <= SKEW_RESET;
    end else begin
      state <= state_next;

      if (req_take) begin
        scan_cnt <= '0;
      end else if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end

      if ((state == ST_FINISH) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      if (cfg.valid) begin
        unique case (cfg.index)
          REG_WINDOW: replay_window  <= cfg.data;
          REG_SKEW:   skew_allowance <= cfg.data;
          default:    ;
        endcase
      end
    end
  end

  // Item and result payload registers need no reset.
  always_ff @(posedge clk) begin
    if (req_take) begin
      q_time  <= req.msg_time;
      q_nonce <= req.msg_nonce;
      q_mac   <= req.mac_match;
      q_pre   <= pre_verdict;
      hit     <= 1'b0;
    end else if (state == ST_SCAN) begin
      hit <= hit || head_match;
    end

    if ((state == ST_FINISH) && out_free) begin
      rsp_accepted <= (final_verdict == VERDICT_OK);
      rsp_verdict  <= final_verdict;
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.accepted = rsp_accepted;
  assign rsp.verdict  = rsp_verdict;

endmodule

`default_nettype wire

// ===== sv/rgc_checker.sv =====
`default_nettype none

module rgc_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       rsp_accepted,
  input logic [2:0] rsp_verdict
);
  import rgc_pkg::*;

  // A result that is not taken stays on the port unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict) &&
                                $stable(rsp_accepted))
    else $error("result changed while stalled");

  // The accepted flag agrees with the verdict code.
  a_accept_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_accepted == (rsp_verdict == VERDICT_OK)))
    else $error("accepted flag disagrees with verdict");

  // Only the defined verdict codes appear.
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_verdict == VERDICT_OK) || (rsp_verdict == VERDICT_OLD) ||
                  (rsp_verdict == VERDICT_FUTURE) || (rsp_verdict == VERDICT_DUP) ||
                  (rsp_verdict == VERDICT_MAC))
    else $error("undefined verdict code");

  // One item at a time: the input closes right after an item is taken.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input reopened while an item is being checked");

  // Reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result present after reset");

endmodule

bind replay_guard_cache_core rgc_checker u_rgc_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_accepted (rsp.accepted),
  .rsp_verdict  (rsp.verdict)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rgc_pkg::*;

  localparam int CACHE_ENTRIES = 16;
  // The core takes one item at a time.
  localparam int ITEM_CYCLES = CACHE_ENTRIES + 2;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 100;
  // The receiver is held off this long once, with the sender still pushing.
  localparam int HOLD_CYCLES = 400;
  // No item of any channel for this many cycles means the core is stuck.
  // This is far above a held-off receiver plus one full item time.
  localparam int HANG_LIMIT = 4000;
  localparam int MAX_REPORTS = 40;

  // Checks each response against a local copy of the nonce cache, the ring
  // slot and the two timing registers. Expected verdicts wait in a queue in
  // the order that their requests were taken.
  class guard_verdicts;
    typedef struct packed {
      logic     accepted;
      verdict_t verdict;
    } outcome_t;

    logic [TIME_W-1:0]  window;
    logic [TIME_W-1:0]  skew;
    logic [TIME_W-1:0]  cached_time [CACHE_ENTRIES];
    logic [NONCE_W-1:0] cached_nonce [CACHE_ENTRIES];
    bit                 cached_valid [CACHE_ENTRIES];
    int unsigned        next_slot;
    outcome_t           verdict_q [$];
    int unsigned        failures;
    int unsigned        results;
    int unsigned        tally [5];

    function new();
      window = WINDOW_RESET;
      skew = SKEW_RESET;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        cached_time[i] = '0;
        cached_nonce[i] = '0;
        cached_valid[i] = 1'b0;
      end
      next_slot = 0;
      failures = 0;
      results = 0;
      for (int i = 0; i < 5; i++) tally[i] = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [TIME_W-1:0] value);
      case (idx)
        REG_WINDOW: window = value;
        REG_SKEW:   skew = value;
        default:    ;
      endcase
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // Runs the four checks in order; the first one that fails decides.
    function void predict_verdict(logic [TIME_W-1:0] ts, logic [NONCE_W-1:0] nonce,
                                  logic [TIME_W-1:0] now, logic mac);
      logic [TIME_W-1:0] age;
      logic [TIME_W-1:0] bound;
      bit                seen;
      verdict_t          v;
      outcome_t          o;
      age = now - ts;
      bound = now + skew;
      seen = 1'b0;
      for (int i = 0; i < CACHE_ENTRIES; i++)
        if (cached_valid[i] && cached_time[i] == ts && cached_nonce[i] == nonce) seen = 1'b1;
      if (age > window) v = VERDICT_OLD;
      else if (ts > bound) v = VERDICT_FUTURE;
      else if (seen) v = VERDICT_DUP;
      else if (!mac) v = VERDICT_MAC;
      else v = VERDICT_OK;
      if (v == VERDICT_OK) begin
        cached_time[next_slot] = ts;
        cached_nonce[next_slot] = nonce;
        cached_valid[next_slot] = 1'b1;
        next_slot = (next_slot + 1) % CACHE_ENTRIES;
      end
      o.accepted = (v == VERDICT_OK);
      o.verdict = v;
      verdict_q.push_back(o);
    endfunction

    function void check_verdict(logic accepted, verdict_t verdict);
      outcome_t want;
      if (verdict_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: unexpected response, accepted=%0b verdict=%0d",
                   $time, accepted, verdict);
        return;
      end
      want = verdict_q.pop_front();
      results++;
      tally[int'(want.verdict)]++;
      if (accepted !== want.accepted) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: accepted mismatch, expected %0b, got %0b",
                   $time, want.accepted, accepted);
      end
      if (verdict !== want.verdict) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: verdict mismatch, expected %0d, got %0d",
                   $time, want.verdict, verdict);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  rgc_req_if req_ch ();
  rgc_rsp_if rsp_ch ();
  rgc_cfg_if cfg_ch ();

  replay_guard_cache_core #(.CACHE_ENTRIES(CACHE_ENTRIES)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  guard_verdicts verdicts = new();

  // Random idling on both sides is switched off for one whole phase.
  bit              idling = 1'b1;
  bit              hold_request = 1'b0;
  int              hold_left = 0;
  int              stuck_cycles = 0;
  int unsigned     settings_written = 0;
  logic [TIME_W-1:0] clock_ms = '0;
  // Recently offered timestamp and nonce pairs; replays of these are how
  // duplicates, and entries already pushed out of the ring, get exercised.
  logic [TIME_W+NONCE_W-1:0] recent_q [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall detector: any item on any channel restarts the count.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= HANG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, HANG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Response side. Results are taken at the rising edge; ready changes at
  // the falling edge, either at random, held off for a long stretch on
  // request, or held high when idling is switched off.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready)
        verdicts.check_verdict(rsp_ch.accepted, rsp_ch.verdict);
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        rsp_ch.ready = 1'b0;
      end else if (hold_left > 0) begin
        rsp_ch.ready = 1'b0;
        hold_left--;
      end else if (idling) begin
        rsp_ch.ready = ($urandom_range(0, 99) >= 20);
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // Offers one request, starting at a falling edge, and returns at the
  // falling edge after it was taken. Valid stays high so that a following
  // request goes out back to back.
  task automatic offer_request(input logic [TIME_W-1:0] ts, input logic [NONCE_W-1:0] nonce,
                               input logic [TIME_W-1:0] now, input logic mac);
    if (idling) begin
      while ($urandom_range(0, 99) < 20) begin
        req_ch.valid = 1'b0;
        @(negedge clk);
      end
      // Now and then a longer gap, which can leave the core idle.
      if ($urandom_range(0, 19) == 0) begin
        req_ch.valid = 1'b0;
        repeat ($urandom_range(1, 2 * ITEM_CYCLES)) @(negedge clk);
      end
    end
    req_ch.valid = 1'b1;
    req_ch.msg_time = ts;
    req_ch.msg_nonce = nonce;
    req_ch.now_time = now;
    req_ch.mac_match = mac;
    do @(posedge clk); while (!req_ch.ready);
    verdicts.predict_verdict(ts, nonce, now, mac);
    @(negedge clk);
  endtask

  // Stops offering and waits until every outstanding verdict has come back.
  task automatic wait_drained();
    req_ch.valid = 1'b0;
    while (verdicts.pending() != 0) @(negedge clk);
  endtask

  task automatic program_register(input cfg_reg_t idx, input logic [TIME_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    do @(posedge clk); while (!cfg_ch.ready);
    verdicts.set_register(idx, value);
    settings_written++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // One random request. Most follow a slowly advancing receiver clock, with
  // ages picked around the window and skew edges and a share of replays;
  // the rest are raw noise over the full field ranges.
  task automatic random_request();
    logic [TIME_W-1:0]  ts;
    logic [NONCE_W-1:0] nonce;
    logic [TIME_W-1:0]  now;
    logic [TIME_W-1:0]  age;
    logic               mac;
    if ($urandom_range(0, 99) < 15) begin
      ts = $urandom;
      nonce = $urandom;
      now = $urandom;
      mac = 1'($urandom_range(0, 1));
    end else begin
      clock_ms = clock_ms + $urandom_range(0, 40);
      now = clock_ms;
      case ($urandom_range(0, 9))
        0: age = '0;
        1: age = verdicts.window;
        2: age = verdicts.window + 1;
        3: age = '0 - verdicts.skew;
        4: age = '0 - verdicts.skew - 1;
        5: age = $urandom;
        default: age = $urandom_range(0, verdicts.window);
      endcase
      ts = now - age;
      nonce = $urandom;
      if (recent_q.size() > 0 && $urandom_range(0, 99) < 35)
        {ts, nonce} = recent_q[$urandom_range(0, recent_q.size() - 1)];
      mac = ($urandom_range(0, 99) < 88);
    end
    recent_q.push_back({ts, nonce});
    if (recent_q.size() > 40) void'(recent_q.pop_front());
    offer_request(ts, nonce, now, mac);
  endtask

  initial begin
    logic [TIME_W-1:0] phase_window [PHASES];
    logic [TIME_W-1:0] phase_skew [PHASES];

    req_ch.valid = 1'b0;
    req_ch.msg_time = '0;
    req_ch.msg_nonce = '0;
    req_ch.now_time = '0;
    req_ch.mac_match = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_WINDOW;
    cfg_ch.data = '0;

    phase_window[0] = WINDOW_RESET;   phase_skew[0] = SKEW_RESET;
    phase_window[1] = '0;             phase_skew[1] = '0;
    phase_window[2] = 32'hFFFF_FFFF;  phase_skew[2] = 32'hFFFF_FFFF;
    phase_window[3] = 32'd1000;       phase_skew[3] = 32'd250;
    phase_window[4] = 32'h7FFF_FFFF;  phase_skew[4] = '0;
    phase_window[5] = $urandom;       phase_skew[5] = $urandom;
    phase_window[6] = 32'hFFFF_FFFF;  phase_skew[6] = SKEW_RESET;
    phase_window[7] = WINDOW_RESET;   phase_skew[7] = 32'hFFFF_FFFF;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default window and skew. The cleared cache holds no valid entries, so
    // an all-zero message must pass the first time only.
    offer_request(32'd0, 32'd0, 32'd0, 1'b1);
    offer_request(32'd0, 32'd0, 32'd0, 1'b1);
    offer_request(32'd1000, 32'd5, 32'd1000, 1'b0);
    offer_request(32'd1000, 32'd5, 32'd1000, 1'b1);
    // Exactly at the window edge, then one past it.
    offer_request(32'd700000, 32'd7, 32'd1000000, 1'b1);
    offer_request(32'd699999, 32'd8, 32'd1000000, 1'b1);
    // A timestamp ahead of now wraps to a huge age, so it reads as too old.
    offer_request(32'd2000, 32'd9, 32'd1000, 1'b1);
    // Age crosses zero but the bound does not wrap: the future rule fires.
    offer_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 1'b1);
    // Now plus skew wraps past zero, so even a current message is in the future.
    offer_request(32'hFFFF_FFF0, 32'hAAAA_5555, 32'hFFFF_FFF0, 1'b1);
    offer_request(32'hFFFF_FFFF, 32'h5555_AAAA, 32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // Widest window: the future rule is now reachable at its exact edge.
    program_register(REG_WINDOW, 32'hFFFF_FFFF);
    offer_request(32'd1060000, 32'd11, 32'd1000000, 1'b1);
    offer_request(32'd1060001, 32'd12, 32'd1000000, 1'b1);
    // A duplicate is reported ahead of a bad code.
    offer_request(32'd1060000, 32'd11, 32'd1000000, 1'b0);
    wait_drained();

    // Zero window and zero skew: only a timestamp equal to now passes.
    program_register(REG_WINDOW, 32'd0);
    program_register(REG_SKEW, 32'd0);
    offer_request(32'd500, 32'd13, 32'd500, 1'b1);
    offer_request(32'd499, 32'd14, 32'd500, 1'b1);
    offer_request(32'd501, 32'd15, 32'd500, 1'b1);
    offer_request(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // Both registers at all ones: the bound becomes now minus one.
    program_register(REG_WINDOW, 32'hFFFF_FFFF);
    program_register(REG_SKEW, 32'hFFFF_FFFF);
    offer_request(32'd0, 32'd16, 32'd1, 1'b1);
    offer_request(32'd1, 32'd17, 32'd1, 1'b1);
    offer_request(32'd0, 32'd19, 32'd1, 1'b0);
    wait_drained();

    // Random phases, each under its own pair of register values. Every
    // phase starts from a drained core; the receiver clock is restarted
    // near the wrap point or at a random place.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      program_register(REG_WINDOW, phase_window[p]);
      program_register(REG_SKEW, phase_skew[p]);
      clock_ms = (p % 2 == 0) ? 32'hFFFF_F000 : $urandom;
      idling = (p != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Hold the receiver off while requests keep coming, so the core
        // fills up and has to stall its input.
        if (p == 4 && i == 30) hold_request = 1'b1;
        // Midway through one phase the sender stops until all is answered.
        if (p == 6 && i == 50) wait_drained();
        random_request();
      end
    end
    idling = 1'b1;

    wait_drained();
    repeat (2 * ITEM_CYCLES) @(posedge clk);

    $display("Checked %0d verdicts over %0d register writes, window and skew from zero to all ones.",
             verdicts.results, settings_written);
    $display("Verdicts seen: ok %0d, too old %0d, future %0d, duplicate %0d, bad code %0d.",
             verdicts.tally[0], verdicts.tally[1], verdicts.tally[2],
             verdicts.tally[3], verdicts.tally[4]);
    if (verdicts.failures == 0 && verdicts.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
